>>> rtl/core/qtu_pkg.sv
// Shared types, widths and constants of the Q table update engine.
`default_nettype none

package qtu_pkg;

    // Fixed-point formats
    localparam int unsigned Q_W      = 32;   // Q value, signed Q16.16
    localparam int unsigned REWARD_W = 25;   // reward, signed Q9.16
    localparam int unsigned FRAC_W   = 16;   // fractional bits
    localparam int unsigned COEF_W   = 17;   // alpha, gamma, epsilon registers
    localparam int unsigned DRAW_W   = 16;
    localparam int unsigned STATE_W  = 6;    // width of state index ports
    localparam int unsigned ACT_W    = 2;    // width of action ports

    // Shared multiplier: unsigned coefficient (zero extended) times signed operand
    localparam int unsigned MUL_A_W  = COEF_W + 1;
    localparam int unsigned MUL_B_W  = 35;
    localparam int unsigned MUL_P_W  = MUL_A_W + MUL_B_W;
    localparam int unsigned RND_W    = MUL_P_W - FRAC_W;
    localparam int unsigned SUM_W    = 38;   // q plus scaled correction

    // One in Q1.16
    localparam logic [COEF_W-1:0] ONE_Q16 = COEF_W'(65536);

    // Register reset values
    localparam logic [COEF_W-1:0] LEARN_RATE_RST = COEF_W'(6554);
    localparam logic [COEF_W-1:0] DISCOUNT_RST   = COEF_W'(64881);
    localparam logic [COEF_W-1:0] EXPLORE_RST    = COEF_W'(3277);

    // Default table geometry
    localparam int unsigned STATES_DEF  = 64;
    localparam int unsigned ACTIONS_DEF = 4;

    // Configuration port
    localparam int unsigned PADDR_W = 4;
    localparam int unsigned PDATA_W = 32;

    typedef enum logic [1:0] {
        REG_LEARN_RATE  = 2'd0,
        REG_DISCOUNT    = 2'd1,
        REG_EXPLORE_THR = 2'd2,
        REG_GREEDY_ONLY = 2'd3
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_CLEAR,   // zero the table after reset
        S_IDLE,    // wait for a transition word
        S_RDQ,     // read Q(prev, action)
        S_RDN,     // read row of next state, one entry a cycle
        S_RDL,     // compare last entry of the row
        S_MG,      // multiply gamma by max
        S_MGW,     // wait for rounded product
        S_DIF,     // form target minus q
        S_MA,      // multiply alpha by difference
        S_MAW,     // wait for rounded product
        S_UPD,     // add, saturate, write back
        S_OUT      // load result word
    } t_state;

    // Clamp a written coefficient to one
    function automatic logic [COEF_W-1:0] clamp_one(input logic [COEF_W-1:0] v);
        clamp_one = (v > ONE_Q16) ? ONE_Q16 : v;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/qtu_mem.sv
// Q table storage: one write port and one registered read port.
`default_nettype none

module qtu_mem #(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned ADDR_W = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [ADDR_W-1:0]        i_waddr,
    input  wire logic [qtu_pkg::Q_W-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0]        i_raddr,
    output logic      [qtu_pkg::Q_W-1:0]  o_rdata
);

    logic [qtu_pkg::Q_W-1:0] r_mem [DEPTH];

    // Write one entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Register the read data
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> rtl/core/qtu_mul.sv
// Shared coefficient multiplier with Q16 round-half-up scaling, two stages.
`default_nettype none

module qtu_mul (
    input  wire logic                                i_clk,
    input  wire logic signed [qtu_pkg::MUL_A_W-1:0]  i_a,
    input  wire logic signed [qtu_pkg::MUL_B_W-1:0]  i_b,
    output logic      signed [qtu_pkg::RND_W-1:0]    o_rnd
);

    localparam logic signed [qtu_pkg::MUL_P_W-1:0] HALF =
        qtu_pkg::MUL_P_W'(1) <<< (qtu_pkg::FRAC_W - 1);

    logic signed [qtu_pkg::MUL_P_W-1:0] r_prod;
    logic signed [qtu_pkg::MUL_P_W-1:0] rnd_sum;

    // Stage one: exact product
    always_ff @(posedge i_clk) begin
        r_prod <= qtu_pkg::MUL_P_W'(i_a) * qtu_pkg::MUL_P_W'(i_b);
    end

    // Stage two: add half and drop fraction (floor)
    assign rnd_sum = r_prod + HALF;

    always_ff @(posedge i_clk) begin
        o_rnd <= rnd_sum[qtu_pkg::MUL_P_W-1:qtu_pkg::FRAC_W];
    end

endmodule

`default_nettype wire

>>> rtl/core/q_table_update_engine.sv
// A word is taken only in idle, and the stall stays high until its result is loaded,
// so a new word waits for the last one. When prev_state equals next_state the row is
// re-read after write back; a terminal word skips the gamma multiply. The single table
// read port and the two dependent passes through the shared multiplier bound throughput.
// Reset: registers return to defaults and the table is zeroed by a pass over all
// STATES*2^ceil(log2(ACTIONS)) entries, during which no word is accepted.
`default_nettype none

module q_table_update_engine #(
    parameter int unsigned STATES  = qtu_pkg::STATES_DEF,
    parameter int unsigned ACTIONS = qtu_pkg::ACTIONS_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // Transition channel
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_stall,
    input  wire logic [qtu_pkg::STATE_W-1:0]          i_prev_state,
    input  wire logic [qtu_pkg::ACT_W-1:0]            i_taken_action,
    input  wire logic signed [qtu_pkg::REWARD_W-1:0]  i_step_reward,
    input  wire logic [qtu_pkg::STATE_W-1:0]          i_next_state,
    input  wire logic                                 i_terminal,
    input  wire logic [qtu_pkg::DRAW_W-1:0]           i_random_draw,
    input  wire logic [qtu_pkg::ACT_W-1:0]            i_random_action,
    // Result channel
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_stall,
    output logic signed [qtu_pkg::Q_W-1:0]            o_new_q,
    output logic [qtu_pkg::ACT_W-1:0]                 o_next_action,
    output logic                                      o_explored,
    output logic                                      o_saturated,
    // Configuration port
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [qtu_pkg::PADDR_W-1:0]          paddr,
    input  wire logic [qtu_pkg::PDATA_W-1:0]          pwdata,
    output logic [qtu_pkg::PDATA_W-1:0]               prdata,
    output logic                                      pready
);

    localparam int unsigned SW     = $clog2(STATES);
    localparam int unsigned AW     = $clog2(ACTIONS);
    localparam int unsigned DEPTH  = STATES << AW;
    localparam int unsigned ADDR_W = SW + AW;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [AW-1:0]     LAST_ACT  = AW'(ACTIONS - 1);

    // Configuration registers
    logic [qtu_pkg::COEF_W-1:0] r_learn_rate;
    logic [qtu_pkg::COEF_W-1:0] r_discount;
    logic [qtu_pkg::COEF_W-1:0] r_explore_thr;
    logic                       r_greedy_only;

    logic             cfg_wr;
    qtu_pkg::t_reg_idx cfg_idx;

    // Sequencer
    qtu_pkg::t_state r_state;
    qtu_pkg::t_state n_state;
    logic [ADDR_W-1:0] r_clr;
    logic [AW-1:0]     r_cnt;
    logic              r_pass2;

    // Latched transition
    logic [SW-1:0]                         r_ps;
    logic [AW-1:0]                         r_act;
    logic signed [qtu_pkg::REWARD_W-1:0]   r_reward;
    logic [SW-1:0]                         r_ns;
    logic                                  r_term;
    logic [qtu_pkg::DRAW_W-1:0]            r_draw;
    logic [AW-1:0]                         r_ract;

    // Working values
    logic signed [qtu_pkg::Q_W-1:0]     r_q;
    logic signed [qtu_pkg::Q_W-1:0]     r_max;
    logic [AW-1:0]                      r_arg;
    logic signed [qtu_pkg::MUL_B_W-1:0] r_diff;
    logic signed [qtu_pkg::Q_W-1:0]     r_nq;
    logic                               r_sat;

    // Clamped inputs
    logic [SW-1:0] ps_c;
    logic [SW-1:0] ns_c;
    logic [AW-1:0] act_c;
    logic [AW-1:0] ract_c;

    // Datapath control from the sequencer
    logic                               in_acc;
    logic                               out_load;
    logic                               mem_we;
    logic [ADDR_W-1:0]                  mem_waddr;
    logic [qtu_pkg::Q_W-1:0]            mem_wdata;
    logic [ADDR_W-1:0]                  mem_raddr;
    logic signed [qtu_pkg::MUL_A_W-1:0] mul_a;
    logic signed [qtu_pkg::MUL_B_W-1:0] mul_b;
    logic                               cmp_en;

    logic [qtu_pkg::Q_W-1:0]            rdata;
    logic signed [qtu_pkg::RND_W-1:0]   rnd;
    logic [AW-1:0]                      cmp_idx;
    logic                               cmp_take;
    logic signed [qtu_pkg::SUM_W-1:0]   sum;
    logic                               sat_hi;
    logic                               sat_lo;
    logic                               explore;

    // Register port decode
    assign pready  = 1'b1;
    assign cfg_idx = qtu_pkg::t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_learn_rate  <= qtu_pkg::LEARN_RATE_RST;
            r_discount    <= qtu_pkg::DISCOUNT_RST;
            r_explore_thr <= qtu_pkg::EXPLORE_RST;
            r_greedy_only <= 1'b0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                qtu_pkg::REG_LEARN_RATE: begin
                    r_learn_rate <= qtu_pkg::clamp_one(pwdata[qtu_pkg::COEF_W-1:0]);
                end
                qtu_pkg::REG_DISCOUNT: begin
                    r_discount <= qtu_pkg::clamp_one(pwdata[qtu_pkg::COEF_W-1:0]);
                end
                qtu_pkg::REG_EXPLORE_THR: begin
                    r_explore_thr <= qtu_pkg::clamp_one(pwdata[qtu_pkg::COEF_W-1:0]);
                end
                qtu_pkg::REG_GREEDY_ONLY: begin
                    r_greedy_only <= pwdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    // Read back registers
    always_comb begin
        case (cfg_idx)
            qtu_pkg::REG_LEARN_RATE:  prdata = qtu_pkg::PDATA_W'(r_learn_rate);
            qtu_pkg::REG_DISCOUNT:    prdata = qtu_pkg::PDATA_W'(r_discount);
            qtu_pkg::REG_EXPLORE_THR: prdata = qtu_pkg::PDATA_W'(r_explore_thr);
            qtu_pkg::REG_GREEDY_ONLY: prdata = qtu_pkg::PDATA_W'(r_greedy_only);
            default:                  prdata = '0;
        endcase
    end

    // Clamp state and action indexes into the table; the random action is reduced by ACTIONS
    assign ps_c = (32'(i_prev_state) >= 32'(STATES)) ? SW'(STATES - 1) : SW'(i_prev_state);
    assign ns_c = (32'(i_next_state) >= 32'(STATES)) ? SW'(STATES - 1) : SW'(i_next_state);
    assign act_c = (32'(i_taken_action) >= 32'(ACTIONS)) ? LAST_ACT : AW'(i_taken_action);
    assign ract_c = (32'(i_random_action) >= 32'(ACTIONS)) ?
                    AW'(32'(i_random_action) - 32'(ACTIONS)) : AW'(i_random_action);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            qtu_pkg::S_CLEAR: begin
                if (r_clr == LAST_ADDR) begin
                    n_state = qtu_pkg::S_IDLE;
                end
            end
            qtu_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = qtu_pkg::S_RDQ;
                end
            end
            qtu_pkg::S_RDQ: n_state = qtu_pkg::S_RDN;
            qtu_pkg::S_RDN: begin
                if (r_cnt == LAST_ACT) begin
                    n_state = qtu_pkg::S_RDL;
                end
            end
            qtu_pkg::S_RDL: begin
                if (r_pass2) begin
                    n_state = qtu_pkg::S_OUT;
                end else if (r_term) begin
                    n_state = qtu_pkg::S_DIF;
                end else begin
                    n_state = qtu_pkg::S_MG;
                end
            end
            qtu_pkg::S_MG:  n_state = qtu_pkg::S_MGW;
            qtu_pkg::S_MGW: n_state = qtu_pkg::S_DIF;
            qtu_pkg::S_DIF: n_state = qtu_pkg::S_MA;
            qtu_pkg::S_MA:  n_state = qtu_pkg::S_MAW;
            qtu_pkg::S_MAW: n_state = qtu_pkg::S_UPD;
            qtu_pkg::S_UPD: begin
                n_state = (r_ps == r_ns) ? qtu_pkg::S_RDN : qtu_pkg::S_OUT;
            end
            qtu_pkg::S_OUT: begin
                if (!o_out_valid || !i_out_stall) begin
                    n_state = qtu_pkg::S_IDLE;
                end
            end
            default: n_state = qtu_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        in_acc    = 1'b0;
        out_load  = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_clr;
        mem_wdata = '0;
        mem_raddr = {r_ns, r_cnt};
        mul_a     = qtu_pkg::MUL_A_W'(r_learn_rate);
        mul_b     = r_diff;
        cmp_en    = 1'b0;
        case (r_state)
            qtu_pkg::S_CLEAR: mem_we = 1'b1;
            qtu_pkg::S_IDLE:  in_acc = i_in_valid;
            qtu_pkg::S_RDQ:   mem_raddr = {r_ps, r_act};
            qtu_pkg::S_RDN:   cmp_en = (r_cnt != '0);
            qtu_pkg::S_RDL:   cmp_en = 1'b1;
            qtu_pkg::S_MG: begin
                mul_a = qtu_pkg::MUL_A_W'(r_discount);
                mul_b = qtu_pkg::MUL_B_W'(r_max);
            end
            qtu_pkg::S_UPD: begin
                mem_we    = 1'b1;
                mem_waddr = {r_ps, r_act};
                mem_wdata = r_nq_next();
            end
            qtu_pkg::S_OUT:   out_load = !o_out_valid || !i_out_stall;
            default: begin
            end
        endcase
    end

    assign o_in_stall = (r_state != qtu_pkg::S_IDLE);

    // Sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= qtu_pkg::S_CLEAR;
            r_clr   <= '0;
            r_cnt   <= '0;
            r_pass2 <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == qtu_pkg::S_CLEAR) begin
                r_clr <= r_clr + ADDR_W'(1);
            end
            if (r_state == qtu_pkg::S_RDN) begin
                r_cnt <= (r_cnt == LAST_ACT) ? '0 : r_cnt + AW'(1);
            end
            if (in_acc) begin
                r_pass2 <= 1'b0;
            end else if (r_state == qtu_pkg::S_UPD) begin
                r_pass2 <= 1'b1;
            end
        end
    end

    // Capture the transition
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_ps     <= ps_c;
            r_act    <= act_c;
            r_reward <= i_step_reward;
            r_ns     <= ns_c;
            r_term   <= i_terminal;
            r_draw   <= i_random_draw;
            r_ract   <= ract_c;
        end
    end

    // Running maximum over the next-state row, first maximum wins
    assign cmp_idx  = (r_state == qtu_pkg::S_RDL) ? LAST_ACT : r_cnt - AW'(1);
    assign cmp_take = (cmp_idx == '0) || ($signed(rdata) > r_max);

    always_ff @(posedge i_clk) begin
        if (r_state == qtu_pkg::S_RDN && r_cnt == '0 && !r_pass2) begin
            r_q <= $signed(rdata);
        end
        if (cmp_en && cmp_take) begin
            r_max <= $signed(rdata);
            r_arg <= cmp_idx;
        end
    end

    // Target minus current value; terminal drops the future term
    always_ff @(posedge i_clk) begin
        if (r_state == qtu_pkg::S_DIF) begin
            r_diff <= qtu_pkg::MUL_B_W'(r_reward)
                    + (r_term ? '0 : qtu_pkg::MUL_B_W'(rnd))
                    - qtu_pkg::MUL_B_W'(r_q);
        end
    end

    // Add correction and saturate to the Q range
    assign sum    = qtu_pkg::SUM_W'(r_q) + qtu_pkg::SUM_W'(rnd);
    assign sat_hi = !sum[qtu_pkg::SUM_W-1] && (sum[qtu_pkg::SUM_W-2:qtu_pkg::Q_W-1] != '0);
    assign sat_lo = sum[qtu_pkg::SUM_W-1] && (sum[qtu_pkg::SUM_W-2:qtu_pkg::Q_W-1] != '1);

    function automatic logic [qtu_pkg::Q_W-1:0] r_nq_next();
        logic [qtu_pkg::Q_W-1:0] v;
        v = sum[qtu_pkg::Q_W-1:0];
        if (sat_hi) begin
            v = {1'b0, {(qtu_pkg::Q_W-1){1'b1}}};
        end else if (sat_lo) begin
            v = {1'b1, {(qtu_pkg::Q_W-1){1'b0}}};
        end
        return v;
    endfunction

    always_ff @(posedge i_clk) begin
        if (r_state == qtu_pkg::S_UPD) begin
            r_nq  <= $signed(mem_wdata);
            r_sat <= sat_hi | sat_lo;
        end
    end

    // Result word register
    assign explore = !r_greedy_only && (qtu_pkg::COEF_W'(r_draw) < r_explore_thr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (out_load) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_new_q       <= r_nq;
            o_next_action <= qtu_pkg::ACT_W'(explore ? r_ract : r_arg);
            o_explored    <= explore;
            o_saturated   <= r_sat;
        end
    end

    qtu_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (rdata)
    );

    qtu_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_rnd (rnd)
    );

endmodule

`default_nettype wire
